// File: rtl/cptc_pkg.sv
// ----------------------------------------------------------------------------
// cptc_pkg
// Shared codes, constants and functions of the carrot pose tracking controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cptc_pkg;

    // path storage depth default
    localparam int PATH_DEPTH_DEF = 256;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_STEP   = 2'd2;

    // status codes
    localparam logic [1:0] ST_DRIVE   = 2'd0;
    localparam logic [1:0] ST_TURN    = 2'd1;
    localparam logic [1:0] ST_REACHED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIST   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BEAR   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEAD   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARROT      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOL     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEAR_OFFSET = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_OFFSET = 4'd7;

    // register reset values
    localparam logic [15:0] GAIN_DIST_RST = 16'd4096;
    localparam logic [15:0] GAIN_BEAR_RST = 16'hFCCD;
    localparam logic [15:0] GAIN_HEAD_RST = 16'hF000;
    localparam logic [23:0] CARROT_RST    = 24'd26214;
    localparam logic [23:0] POS_TOL_RST   = 24'd6554;
    localparam logic [23:0] MAX_LIN_RST   = 24'd26214;

    // angle tolerances in binary angle units (0.1 rad and 0.01 rad)
    localparam logic signed [15:0] ANG_TOL_SEARCH = 16'sd1043;
    localparam logic signed [15:0] ANG_TOL_GOAL   = 16'sd104;

    // pi in Q29
    localparam logic [31:0] PI_Q29 = 32'd1686629713;

    // iteration counts of the shared units
    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 32;

    // arctangent table, 2^32 is a full turn
    function automatic logic [31:0] cptc_atan(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cptc_if.sv
// ----------------------------------------------------------------------------
// cptc_if
// Valid/ready channel interfaces for command input and drive result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface cptc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] yaw;

    modport source (output valid, cmd, pos_x, pos_y, yaw, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, yaw, output ready);
endinterface

interface cptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic [1:0]         status;
    logic [7:0]         goal_index;

    modport source (output valid, linear_speed, angular_speed, status, goal_index,
                    input ready);
    modport sink   (input valid, linear_speed, angular_speed, status, goal_index,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/cptc_ram.sv
// ----------------------------------------------------------------------------
// cptc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cptc_sqrt.sv
// ----------------------------------------------------------------------------
// cptc_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cptc_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    import cptc_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [35:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] n_reg;
    logic [35:0] rem_t;
    logic [35:0] trial;
    logic        fits;

    // trial subtraction of one root digit
    assign rem_t = {rem_reg[33:0], n_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits  = rem_t >= trial;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_t - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/cptc_cordic.sv
// ----------------------------------------------------------------------------
// cptc_cordic
// Iterative vectoring CORDIC giving the bearing of a vector as a binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module cptc_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] x_in,
    input  wire logic signed [32:0] y_in,
    output logic                    done,
    output logic signed [15:0]      angle
);
    import cptc_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic [31:0]        acc_reg;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic [31:0]        acc_round;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rotation toward the x axis, left half plane flipped by pi first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in < 0)
            begin
                x_reg   <= -36'(x_in);
                y_reg   <= -36'(y_in);
                acc_reg <= 32'h8000_0000;
            end
            else
            begin
                x_reg   <= 36'(x_in);
                y_reg   <= 36'(y_in);
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + cptc_atan(cnt_reg);
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - cptc_atan(cnt_reg);
            end
        end
    end

    // round to 16 bits
    assign acc_round = acc_reg + 32'h0000_8000;
    assign angle     = $signed(acc_round[31:16]);
    assign done      = done_reg;

endmodule

`default_nettype wire

// File: rtl/carrot_pose_tracking_controller.sv
// ----------------------------------------------------------------------------
// carrot_pose_tracking_controller
// Path following drive controller: goal search, polar errors and speed output.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries commands: clear path, append a path pose, or a control step
//  with the robot pose. Only a step produces a transfer on out_ch (linear and
//  angular speed, status, goal index). Clear and append are handled in idle.
//  A step walks the path from the current goal; each visited point costs a
//  RAM read, two squares on the shared multiplier and a square root. The
//  chosen goal then takes a CORDIC bearing plus three multiplies when
//  driving, or only the angular multiplies when turning. in_ch is not
//  ready from a step's transfer until its result is loaded. The square
//  root unit is the longest part of each point.
//  The finished result sits in an output register; a stalled receiver holds
//  the block in its final state until the register frees.
//  Reset empties the path, zeroes the goal pointer and loads the register
//  defaults; path memory contents are not cleared. Configuration writes go
//  through cfg_we/cfg_index/cfg_data; the user must make them only while the
//  block is idle, which the block itself leaves unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

module carrot_pose_tracking_controller #(
    parameter int PATH_DEPTH = cptc_pkg::PATH_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cptc_in_if.sink                             in_ch,
    cptc_out_if.source                          out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [cptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cptc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cptc_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int RW = 80;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_READ  = 14'b00000000000010,
        S_LOAD  = 14'b00000000000100,
        S_SQA   = 14'b00000000001000,
        S_SQB   = 14'b00000000010000,
        S_SUM   = 14'b00000000100000,
        S_ROOT  = 14'b00000001000000,
        S_EVAL  = 14'b00000010000000,
        S_CST   = 14'b00000100000000,
        S_ANGLE = 14'b00001000000000,
        S_LIN   = 14'b00010000000000,
        S_ANG1  = 14'b00100000000000,
        S_ANG2  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [15:0] gain_dist_reg, gain_bear_reg, gain_head_reg;
    logic [23:0]        carrot_reg, pos_tol_reg, max_lin_reg;
    logic signed [15:0] bear_off_reg, head_off_reg;

    // path state
    logic [CW-1:0] count_reg;
    logic [AW-1:0] gp_reg;
    logic [AW-1:0] i_reg;

    // step datapath
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [15:0] ryaw_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [15:0] yaw_reg;
    logic               hfar_reg;
    logic               big_reg;
    logic [63:0]        sq_reg;
    logic signed [63:0] prod_reg;
    logic [33:0]        rho_reg;
    logic signed [15:0] err_reg;
    logic signed [31:0] lin_reg;
    logic [1:0]         status_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_lin_reg, out_ang_reg;
    logic [1:0]         out_status_reg;
    logic [7:0]         out_gi_reg;

    // memory
    logic          ram_we;
    logic [RW-1:0] ram_wdata, ram_rdata;

    // combinational helpers
    logic               in_xfer;
    logic               fin_load;
    logic [32:0]        dxa, dya;
    logic               big;
    logic [31:0]        axs, ays;
    logic signed [34:0] mult_a;
    logic signed [32:0] mult_b;
    logic signed [67:0] prod_full;
    logic [63:0]        radicand;
    logic               sqrt_start, sqrt_done;
    logic [31:0]        root;
    logic               cordic_start, cordic_done;
    logic signed [15:0] bearing;
    logic [33:0]        rho;
    logic               last_pt;
    logic               qualify;
    logic signed [15:0] herr;
    logic signed [15:0] ediff;
    logic signed [15:0] berr_drive;
    logic signed [63:0] lin_shift;
    logic signed [31:0] lin_clamp;
    logic signed [63:0] ang_shift;
    logic signed [31:0] px, py;
    logic signed [15:0] pyaw;
    logic [31:0]        gp_wide;

    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // result loads when the output register is free or leaving
    assign fin_load = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    // path memory: x, y, yaw packed into one word
    assign ram_we    = in_xfer && (in_ch.cmd == CMD_APPEND) && (count_reg < CW'(PATH_DEPTH));
    assign ram_wdata = {in_ch.pos_x, in_ch.pos_y, in_ch.yaw};

    cptc_ram #(
        .WIDTH (RW),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (i_reg),
        .rdata (ram_rdata)
    );

    assign px   = $signed(ram_rdata[79:48]);
    assign py   = $signed(ram_rdata[47:16]);
    assign pyaw = $signed(ram_rdata[15:0]);

    // absolute offsets, halved when either needs 32 bits
    assign dxa = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign dya = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign big = dxa[32] | dxa[31] | dya[32] | dya[31];
    assign axs = big ? dxa[32:1] : dxa[31:0];
    assign ays = big ? dya[32:1] : dya[31:0];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_SQA:
            begin
                mult_a = $signed({3'b000, axs});
                mult_b = $signed({1'b0, axs});
            end
            S_SQB:
            begin
                mult_a = $signed({3'b000, ays});
                mult_b = $signed({1'b0, ays});
            end
            S_LIN:
            begin
                mult_a = $signed({1'b0, rho_reg});
                mult_b = 33'(gain_dist_reg);
            end
            S_ANG1:
            begin
                mult_a = 35'(err_reg);
                mult_b = (status_reg == ST_DRIVE) ? 33'(gain_bear_reg) : 33'(gain_head_reg);
            end
            S_ANG2:
            begin
                mult_a = 35'($signed(prod_reg[31:0]));
                mult_b = $signed({1'b0, PI_Q29});
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign prod_full = mult_a * mult_b;

    // square root and bearing units
    assign radicand   = sq_reg + prod_reg;
    assign sqrt_start = (state_reg == S_SUM);

    cptc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    assign cordic_start = (state_reg == S_CST);

    cptc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (dx_reg),
        .y_in  (dy_reg),
        .done  (cordic_done),
        .angle (bearing)
    );

    // point evaluation
    assign rho        = big_reg ? {1'b0, root, 1'b0} : {2'b00, root};
    assign last_pt    = (CW'(i_reg) + CW'(1)) == count_reg;
    assign qualify    = (rho >= 34'(carrot_reg)) || hfar_reg;
    assign herr       = ryaw_reg - yaw_reg - head_off_reg;
    assign ediff      = ryaw_reg - pyaw;
    assign berr_drive = ryaw_reg - bearing - bear_off_reg;

    // linear speed clamp
    assign lin_shift = prod_reg >>> 12;
    always_comb
    begin
        if (lin_shift > $signed({40'd0, max_lin_reg}))
        begin
            lin_clamp = $signed({8'd0, max_lin_reg});
        end
        else if (lin_shift < -64'sd2147483648)
        begin
            lin_clamp = 32'sh8000_0000;
        end
        else
        begin
            lin_clamp = lin_shift[31:0];
        end
    end

    assign ang_shift = prod_reg >>> 40;
    assign gp_wide   = 32'(gp_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_dist_reg <= GAIN_DIST_RST;
            gain_bear_reg <= GAIN_BEAR_RST;
            gain_head_reg <= GAIN_HEAD_RST;
            carrot_reg    <= CARROT_RST;
            pos_tol_reg   <= POS_TOL_RST;
            max_lin_reg   <= MAX_LIN_RST;
            bear_off_reg  <= '0;
            head_off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_DIST:   gain_dist_reg <= cfg_data[15:0];
                REG_GAIN_BEAR:   gain_bear_reg <= cfg_data[15:0];
                REG_GAIN_HEAD:   gain_head_reg <= cfg_data[15:0];
                REG_CARROT:      carrot_reg    <= cfg_data;
                REG_POS_TOL:     pos_tol_reg   <= cfg_data;
                REG_MAX_LIN:     max_lin_reg   <= cfg_data;
                REG_BEAR_OFFSET: bear_off_reg  <= cfg_data[15:0];
                REG_HEAD_OFFSET: head_off_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            gp_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        unique case (in_ch.cmd)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                gp_reg    <= '0;
                            end
                            CMD_APPEND:
                            begin
                                if (ram_we)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            CMD_STEP:
                            begin
                                state_reg <= (count_reg == '0) ? S_FIN : S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ:  state_reg <= S_LOAD;
                S_LOAD:  state_reg <= S_SQA;
                S_SQA:   state_reg <= S_SQB;
                S_SQB:   state_reg <= S_SUM;
                S_SUM:   state_reg <= S_ROOT;
                S_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (qualify || last_pt)
                    begin
                        gp_reg <= i_reg;
                        if (rho > 34'(pos_tol_reg))
                        begin
                            state_reg <= S_CST;
                        end
                        else if (herr >= ANG_TOL_GOAL || herr <= -ANG_TOL_GOAL)
                        begin
                            state_reg <= S_ANG1;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_CST:   state_reg <= S_ANGLE;
                S_ANGLE:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= S_LIN;
                    end
                end
                S_LIN:   state_reg <= S_ANG1;
                S_ANG1:  state_reg <= S_ANG2;
                S_ANG2:  state_reg <= S_FIN;
                S_FIN:
                begin
                    if (fin_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // step datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                rx_reg     <= in_ch.pos_x;
                ry_reg     <= in_ch.pos_y;
                ryaw_reg   <= in_ch.yaw;
                i_reg      <= gp_reg;
                lin_reg    <= '0;
                prod_reg   <= '0;
                status_reg <= ST_EMPTY;
            end
            S_LOAD:
            begin
                dx_reg   <= 33'(px) - 33'(rx_reg);
                dy_reg   <= 33'(py) - 33'(ry_reg);
                yaw_reg  <= pyaw;
                hfar_reg <= (ediff > ANG_TOL_SEARCH) || (ediff < -ANG_TOL_SEARCH);
            end
            S_SQA:
            begin
                big_reg  <= big;
                prod_reg <= 64'(prod_full);
            end
            S_SQB:
            begin
                sq_reg   <= prod_reg;
                prod_reg <= 64'(prod_full);
            end
            S_EVAL:
            begin
                rho_reg  <= rho;
                i_reg    <= i_reg + AW'(1);
                prod_reg <= '0;
                lin_reg  <= '0;
                err_reg  <= herr;
                if (rho > 34'(pos_tol_reg))
                begin
                    status_reg <= ST_DRIVE;
                end
                else if (herr >= ANG_TOL_GOAL || herr <= -ANG_TOL_GOAL)
                begin
                    status_reg <= ST_TURN;
                end
                else
                begin
                    status_reg <= ST_REACHED;
                end
            end
            S_ANGLE:
            begin
                err_reg <= berr_drive;
            end
            S_LIN:
            begin
                prod_reg <= 64'(prod_full);
            end
            S_ANG1:
            begin
                if (status_reg == ST_DRIVE)
                begin
                    lin_reg <= lin_clamp;
                end
                prod_reg <= 64'(prod_full);
            end
            S_ANG2:
            begin
                prod_reg <= 64'(prod_full);
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    out_lin_reg    <= lin_reg;
                    out_ang_reg    <= ang_shift[31:0];
                    out_status_reg <= status_reg;
                    out_gi_reg     <= gp_wide[7:0];
                end
            end
            default: ;
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.linear_speed  = out_lin_reg;
    assign out_ch.angular_speed = out_ang_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.goal_index    = out_gi_reg;

`ifndef SYNTH
    // path never holds more points than the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PATH_DEPTH))
        else $error("path count above depth");

    // goal pointer stays inside a non-empty path
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CW'(gp_reg) < count_reg))
        else $error("goal pointer outside path");

    // empty path result carries zero speeds and goal index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY) |->
        (out_lin_reg == 0 && out_ang_reg == 0 && out_gi_reg == 8'd0))
        else $error("empty path result not zero");

    // no forward speed unless driving
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_DRIVE) |-> (out_lin_reg == 0))
        else $error("linear speed outside driving");

    // a new result is only loaded once the previous one has left
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("result dropped");
`endif

endmodule

`default_nettype wire
